>>> src/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// shared types and constants for the ps/2 mouse packet cursor tracker
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mct_pkg;

    // mouse protocol bytes and header fields
    localparam logic [7:0] ACK_BYTE     = 8'hFA;
    localparam logic [7:0] HDR_MASK     = 8'hC8;
    localparam logic [7:0] HDR_MATCH    = 8'h08;
    localparam int         HDR_XSIGN    = 4;
    localparam int         HDR_YSIGN    = 5;
    localparam int         BUTTON_BITS  = 3;

    // register reset values, truncated to the coordinate width on use
    localparam logic [15:0] MAX_X_RESET   = 16'd304;
    localparam logic [15:0] MAX_Y_RESET   = 16'd184;
    localparam logic [15:0] START_X_RESET = 16'd152;
    localparam logic [15:0] START_Y_RESET = 16'd78;

    // configuration register index
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MAX_X   = 3'd0,
        REG_MAX_Y   = 3'd1,
        REG_START_X = 3'd2,
        REG_START_Y = 3'd3
    } cfg_reg_t;

    // packet phase
    typedef enum logic [1:0] {
        PH_ACK    = 2'd0,
        PH_HEADER = 2'd1,
        PH_X      = 2'd2,
        PH_Y      = 2'd3
    } phase_t;

    // decoded packet handed to the cursor and result stages
    typedef struct packed {
        logic                    valid;
        logic signed [8:0]       move_x;
        logic signed [9:0]       move_y;
        logic [BUTTON_BITS-1:0]  buttons;
    } pkt_t;

    // cursor update and register write strobes
    typedef struct packed {
        logic step;
        logic wr_max_x;
        logic wr_max_y;
        logic wr_start_x;
        logic wr_start_y;
    } cursor_ctrl_t;

endpackage

`default_nettype wire

>>> src/ps2_mouse_packet_cursor_tracker_unit.sv
// a byte accepted sits in the input register, and when it is the third of a packet
//   its result goes to the result register; the add and clamp are combinational
// throughput: one byte per cycle unless a held result stalls a full input register
// reset: waits for the 0xFA acknowledge, cursor at the start reset values,
//   bounds at the max reset values, both registers empty
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_unit
// ps/2 mouse three-byte packet decoder with clamped cursor tracking
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_cursor_tracker_unit #(
    parameter int COORD_BITS = 12
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    // byte input channel
    input  wire                                      s_valid,
    output logic                                     s_ready,
    input  wire [7:0]                                s_rx_byte,
    // result channel
    output logic                                     m_valid,
    input  wire                                      m_ready,
    output logic signed [8:0]                        m_move_x,
    output logic signed [9:0]                        m_move_y,
    output logic [ps2mct_pkg::BUTTON_BITS-1:0]       m_buttons,
    output logic [COORD_BITS-1:0]                    m_pos_x,
    output logic [COORD_BITS-1:0]                    m_pos_y,
    // configuration write channel
    input  wire                                      cfg_valid,
    output logic                                     cfg_ready,
    input  wire [ps2mct_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire [COORD_BITS-1:0]                     cfg_data
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // result register
    logic                                   out_valid_reg, out_valid_next;
    logic signed [8:0]                      out_move_x_reg;
    logic signed [9:0]                      out_move_y_reg;
    logic [ps2mct_pkg::BUTTON_BITS-1:0]     out_buttons_reg;
    logic [COORD_BITS-1:0]                  out_pos_x_reg;
    logic [COORD_BITS-1:0]                  out_pos_y_reg;

    logic                      advance;
    logic                      cfg_write;
    ps2mct_pkg::pkt_t          pkt;
    ps2mct_pkg::cursor_ctrl_t  cur_ctrl;
    logic [COORD_BITS-1:0]     pos_x_next;
    logic [COORD_BITS-1:0]     pos_y_next;

    // the buffered byte moves on whenever the result register can take a result,
    // so a waiting result only stalls input once the input register is full
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // configuration writes are always taken; unknown indexes fall through
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        cur_ctrl            = '0;
        cur_ctrl.step       = pkt.valid;
        if (cfg_write) begin
            case (cfg_index)
                ps2mct_pkg::REG_MAX_X:   cur_ctrl.wr_max_x   = 1'b1;
                ps2mct_pkg::REG_MAX_Y:   cur_ctrl.wr_max_y   = 1'b1;
                ps2mct_pkg::REG_START_X: cur_ctrl.wr_start_x = 1'b1;
                ps2mct_pkg::REG_START_Y: cur_ctrl.wr_start_y = 1'b1;
                default: ;
            endcase
        end
    end

    // packet sequencer
    ps2mct_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .pkt     (pkt)
    );

    // cursor accumulate and clamp
    ps2mct_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (cur_ctrl),
        .cfg_data   (cfg_data),
        .move_x     (pkt.move_x),
        .move_y     (pkt.move_y),
        .pos_x_next (pos_x_next),
        .pos_y_next (pos_y_next)
    );

    // result register: loads on the third byte, clears when the transaction completes
    always_comb begin
        out_valid_next = out_valid_reg;
        if (pkt.valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt.valid) begin
            out_move_x_reg  <= pkt.move_x;
            out_move_y_reg  <= pkt.move_y;
            out_buttons_reg <= pkt.buttons;
            out_pos_x_reg   <= pos_x_next;
            out_pos_y_reg   <= pos_y_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_move_x  = out_move_x_reg;
    assign m_move_y  = out_move_y_reg;
    assign m_buttons = out_buttons_reg;
    assign m_pos_x   = out_pos_x_reg;
    assign m_pos_y   = out_pos_y_reg;

    // a decoded packet always lands in the result register
    a_pkt_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt.valid |=> out_valid_reg)
        else $error("decoded packet did not reach the result register");

    // a new result only appears after the input register moved a byte on
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without a byte being consumed");

    // a stalled result with a full input register blocks new bytes
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg) |-> !s_ready)
        else $error("input taken while both stages are full");

    // a packet is never decoded from an empty input register
    a_pkt_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt.valid |-> in_valid_reg)
        else $error("packet decoded without a buffered byte");

endmodule

`default_nettype wire

>>> src/ps2mct_decoder.sv
// ----------------------------------------------------------------------------
// ps2mct_decoder
// byte sequencer: waits for the acknowledge, then collects three-byte packets
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mct_decoder (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               step,
    input  wire [7:0]         rx_byte,
    output ps2mct_pkg::pkt_t  pkt
);

    ps2mct_pkg::phase_t phase_reg, phase_next;
    logic [7:0]         header_reg;
    logic [7:0]         x_byte_reg;
    logic               header_ok;
    logic [8:0]         y_wide;

    assign header_ok = (rx_byte & ps2mct_pkg::HDR_MASK) == ps2mct_pkg::HDR_MATCH;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            case (phase_reg)
                ps2mct_pkg::PH_ACK: begin
                    if (rx_byte == ps2mct_pkg::ACK_BYTE) begin
                        phase_next = ps2mct_pkg::PH_HEADER;
                    end
                end
                ps2mct_pkg::PH_HEADER: begin
                    if (header_ok) begin
                        phase_next = ps2mct_pkg::PH_X;
                    end
                end
                ps2mct_pkg::PH_X: phase_next = ps2mct_pkg::PH_Y;
                ps2mct_pkg::PH_Y: phase_next = ps2mct_pkg::PH_HEADER;
                default:          phase_next = ps2mct_pkg::PH_ACK;
            endcase
        end
    end

    // packet outputs, y byte negated to screen direction
    assign y_wide = {header_reg[ps2mct_pkg::HDR_YSIGN], rx_byte};

    always_comb begin
        pkt.valid   = step && (phase_reg == ps2mct_pkg::PH_Y);
        pkt.move_x  = $signed({header_reg[ps2mct_pkg::HDR_XSIGN], x_byte_reg});
        pkt.move_y  = $signed(10'd0 - {y_wide[8], y_wide});
        pkt.buttons = header_reg[ps2mct_pkg::BUTTON_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ps2mct_pkg::PH_ACK;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && phase_reg == ps2mct_pkg::PH_HEADER && header_ok) begin
            header_reg <= rx_byte;
        end
        if (step && phase_reg == ps2mct_pkg::PH_X) begin
            x_byte_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> src/ps2mct_cursor.sv
// ----------------------------------------------------------------------------
// ps2mct_cursor
// cursor position accumulator with clamping and bound registers
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mct_cursor #(
    parameter int COORD_BITS = 12
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  ps2mct_pkg::cursor_ctrl_t     ctrl,
    input  wire [COORD_BITS-1:0]         cfg_data,
    input  wire signed [8:0]             move_x,
    input  wire signed [9:0]             move_y,
    output logic [COORD_BITS-1:0]        pos_x_next,
    output logic [COORD_BITS-1:0]        pos_y_next
);

    localparam int SUM_W = COORD_BITS + 2;

    logic [COORD_BITS-1:0] max_x_reg;
    logic [COORD_BITS-1:0] max_y_reg;
    logic [COORD_BITS-1:0] cursor_x_reg;
    logic [COORD_BITS-1:0] cursor_y_reg;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    // negative goes to zero first, then above max goes to max
    function automatic logic [COORD_BITS-1:0] clamp(
        input logic signed [SUM_W-1:0] sum,
        input logic [COORD_BITS-1:0]   limit
    );
        logic [COORD_BITS-1:0] res;
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (sum[SUM_W-2:0] > {1'b0, limit}) begin
            res = limit;
        end else begin
            res = sum[COORD_BITS-1:0];
        end
        return res;
    endfunction

    assign sum_x = $signed({2'b00, cursor_x_reg})
                 + $signed({{(SUM_W-9){move_x[8]}}, move_x});
    assign sum_y = $signed({2'b00, cursor_y_reg})
                 + $signed({{(SUM_W-10){move_y[9]}}, move_y});

    assign pos_x_next = clamp(sum_x, max_x_reg);
    assign pos_y_next = clamp(sum_y, max_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_x_reg    <= COORD_BITS'(ps2mct_pkg::MAX_X_RESET);
            max_y_reg    <= COORD_BITS'(ps2mct_pkg::MAX_Y_RESET);
            cursor_x_reg <= COORD_BITS'(ps2mct_pkg::START_X_RESET);
            cursor_y_reg <= COORD_BITS'(ps2mct_pkg::START_Y_RESET);
        end else begin
            if (ctrl.wr_max_x) begin
                max_x_reg <= cfg_data;
            end
            if (ctrl.wr_max_y) begin
                max_y_reg <= cfg_data;
            end
            if (ctrl.wr_start_x) begin
                cursor_x_reg <= cfg_data;
            end else if (ctrl.step) begin
                cursor_x_reg <= pos_x_next;
            end
            if (ctrl.wr_start_y) begin
                cursor_y_reg <= cfg_data;
            end else if (ctrl.step) begin
                cursor_y_reg <= pos_y_next;
            end
        end
    end

endmodule

`default_nettype wire
